// File: hdl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants for the indexed list store
// Transaction structs, operation and status codes, and the control word
// that steers every cell of the storage row.
// ----------------------------------------------------------------------------
package ils_pkg;

  // Storage geometry
  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);

  // Field widths fixed by the transaction format
  localparam int OP_W    = 2;
  localparam int POS_W   = 5;
  localparam int CNT_W   = 5;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 2;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_SET    = 2'd3
  } op_e;

  // Status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // What each cell does this cycle
  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_INSERT = 2'd1,
    CM_REMOVE = 2'd2,
    CM_WRITE  = 2'd3
  } cell_mode_e;

  // Request transaction
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] data_in;
  } ils_in_t;

  // Response transaction
  typedef struct packed {
    logic [WORD_W-1:0] data_out;
    logic [CNT_W-1:0]  count_after;
    logic [STAT_W-1:0] status;
  } ils_out_t;

  // Broadcast control word for the cell row
  typedef struct packed {
    cell_mode_e            mode;
    logic [IDX_W-1:0]      idx;
    logic [IDX_W-1:0]      rd_idx;
    logic [DATA_WIDTH-1:0] data;
  } cell_ctrl_t;

endpackage

// File: hdl/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store: bounded ordered list of words addressed by position
// Decodes each request against the entry count, steers the cell row and
// registers the response.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req (op, position, data_in) under req_valid and
//   req_ready; responses leave on rsp (data_out, count_after, status) under
//   rsp_valid and rsp_ready. Every request gives exactly one response.
//   Ops: insert at 0..count, remove at 0..count (count removes the last
//   entry), get, and set (at count it appends). Failed requests report
//   range, empty or full status and leave the list untouched.
//   The response is registered and valid in the cycle after the request transaction.
//   Throughput: one transaction per cycle; the whole row of cells shifts,
//   writes or holds in the cycle of the request, so the only limit is the
//   single response register.
//   A stalled receiver holds rsp; req_ready stays high while the response
//   register is empty or being drained in the same cycle.
//   Reset (rst, synchronous) empties the list and drops any pending
//   response; entry contents are not cleared and are never read until
//   written.
// ----------------------------------------------------------------------------
module indexed_list_store (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  ils_pkg::ils_in_t req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output ils_pkg::ils_out_t rsp
);
  import ils_pkg::*;

  logic [CNT_W-1:0]      entry_count;
  logic [CNT_W-1:0]      entry_count_next;
  logic                  accept;
  logic                  full;
  logic                  empty;
  cell_ctrl_t            ctrl;
  cell_mode_e            mode;
  logic [IDX_W-1:0]      rd_idx;
  logic [IDX_W-1:0]      cmd_idx;
  logic                  take_rd;
  logic                  take_din;
  logic [STAT_W-1:0]     rsp_status;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH-1:0] din;
  ils_out_t              rsp_next;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign full      = (entry_count >= CNT_W'(CAPACITY));
  assign empty     = (entry_count == '0);
  assign din       = DATA_WIDTH'(req.data_in);

  // Read address: remove at the count reads the last entry
  always_comb begin
    rd_idx = req.position[IDX_W-1:0];
    if (req.op == OP_REMOVE && req.position == entry_count) begin
      rd_idx = IDX_W'(entry_count - CNT_W'(1));
    end
  end

  // Request decode: status, cell command, response word source
  always_comb begin
    mode             = CM_HOLD;
    cmd_idx          = req.position[IDX_W-1:0];
    entry_count_next = entry_count;
    take_rd          = 1'b0;
    take_din         = 1'b0;
    rsp_status       = ST_OK;
    unique case (req.op)
      OP_INSERT: begin
        priority if (req.position > entry_count) begin
          rsp_status = ST_RANGE;
        end else if (full) begin
          rsp_status = ST_FULL;
        end else begin
          mode             = CM_INSERT;
          entry_count_next = entry_count + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        priority if (empty) begin
          rsp_status = ST_EMPTY;
        end else if (req.position > entry_count) begin
          rsp_status = ST_RANGE;
        end else begin
          mode             = CM_REMOVE;
          cmd_idx          = rd_idx;
          take_rd          = 1'b1;
          entry_count_next = entry_count - CNT_W'(1);
        end
      end
      OP_GET: begin
        priority if (empty) begin
          rsp_status = ST_EMPTY;
        end else if (req.position >= entry_count) begin
          rsp_status = ST_RANGE;
        end else begin
          take_rd = 1'b1;
        end
      end
      OP_SET: begin
        priority if (req.position > entry_count) begin
          rsp_status = ST_RANGE;
        end else if (req.position == entry_count) begin
          // append
          if (full) begin
            rsp_status = ST_FULL;
          end else begin
            mode             = CM_INSERT;
            entry_count_next = entry_count + CNT_W'(1);
          end
        end else begin
          mode     = CM_WRITE;
          take_din = 1'b1;
        end
      end
      default: mode = CM_HOLD;
    endcase
  end

  // Cell row command; the row only moves on an accepted request
  assign ctrl = '{mode:   accept ? mode : CM_HOLD,
                  idx:    cmd_idx,
                  rd_idx: rd_idx,
                  data:   din};

  // Response word
  assign rsp_next = '{data_out:    take_rd  ? WORD_W'(rd_data) :
                                   take_din ? WORD_W'(din) : '0,
                      count_after: entry_count_next,
                      status:      rsp_status};

  ils_row u_row (
    .clk     (clk),
    .ctrl    (ctrl),
    .rd_data (rd_data)
  );

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (accept) begin
      entry_count <= entry_count_next;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  // Count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // The response reports the count the list now holds
  a_rsp_count: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid && rsp.count_after == entry_count)
    else $error("response count differs from stored count");

  // A failed request leaves the count untouched
  a_fail_hold: assert property (@(posedge clk) disable iff (rst)
    accept && rsp_next.status != ST_OK |=> entry_count == $past(entry_count))
    else $error("failed request changed the count");

  // Failed requests return a zero word
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    accept && rsp_next.status != ST_OK |=> rsp.data_out == '0)
    else $error("failed request returned data");
`endif

endmodule

// File: hdl/ils_cell.sv
// ----------------------------------------------------------------------------
// ils_cell: one storage slot of the list
// Holds a single entry; compares its own slot number with the broadcast
// index and takes its left neighbour, right neighbour or new data.
// ----------------------------------------------------------------------------
module ils_cell (
  input  logic                          clk,
  input  ils_pkg::cell_ctrl_t           ctrl,
  input  logic [ils_pkg::IDX_W-1:0]     slot,
  input  logic [ils_pkg::DATA_WIDTH-1:0] left,
  input  logic [ils_pkg::DATA_WIDTH-1:0] right,
  output logic [ils_pkg::DATA_WIDTH-1:0] value,
  output logic [ils_pkg::DATA_WIDTH-1:0] tap
);
  import ils_pkg::*;

  logic [DATA_WIDTH-1:0] value_next;

  // Next entry value from the broadcast command
  always_comb begin
    value_next = value;
    unique case (ctrl.mode)
      CM_HOLD: value_next = value;
      CM_INSERT: begin
        priority if (slot > ctrl.idx) begin
          value_next = left;
        end else if (slot == ctrl.idx) begin
          value_next = ctrl.data;
        end else begin
          value_next = value;
        end
      end
      CM_REMOVE: begin
        if (slot >= ctrl.idx) begin
          value_next = right;
        end
      end
      CM_WRITE: begin
        if (slot == ctrl.idx) begin
          value_next = ctrl.data;
        end
      end
      default: value_next = value;
    endcase
  end

  // Entry register, payload only
  always_ff @(posedge clk) begin
    value <= value_next;
  end

  // Read tap: only the addressed cell drives a non-zero word
  assign tap = (slot == ctrl.rd_idx) ? value : '0;

endmodule

// File: hdl/ils_row.sv
// ----------------------------------------------------------------------------
// ils_row: the row of storage cells
// Chains the cells to their neighbours and merges their read taps into
// the single read word.
// ----------------------------------------------------------------------------
module ils_row (
  input  logic                           clk,
  input  ils_pkg::cell_ctrl_t            ctrl,
  output logic [ils_pkg::DATA_WIDTH-1:0] rd_data
);
  import ils_pkg::*;

  logic [DATA_WIDTH-1:0] values [CAPACITY];
  logic [DATA_WIDTH-1:0] taps   [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_in;
    logic [DATA_WIDTH-1:0] right_in;

    // Ends of the chain see zero
    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = values[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = values[i+1];
    end

    ils_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .slot  (IDX_W'(i)),
      .left  (left_in),
      .right (right_in),
      .value (values[i]),
      .tap   (taps[i])
    );
  end

  // OR-merge of the taps; at most one is non-zero
  always_comb begin
    rd_data = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_data = rd_data | taps[k];
    end
  end

endmodule

// File: dv/ils_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ils_list_checker: response checker for the indexed list store
// Watches both channels. Every accepted request is run through a local
// model of the list, and the response it should produce is queued. Every
// accepted response is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module ils_list_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  logic                      req_ready,
  input  ils_pkg::ils_in_t          req,
  input  logic                      rsp_valid,
  input  logic                      rsp_ready,
  input  ils_pkg::ils_out_t         rsp,
  output int                        mismatches,
  output int                        outstanding,
  output int                        checked,
  output int                        full_hits,
  output int                        empty_hits,
  output logic [ils_pkg::CNT_W-1:0] list_count
);
  import ils_pkg::*;

  // Local copy of the list contents and length
  logic [DATA_WIDTH-1:0] stored_words [CAPACITY];
  int unsigned           word_count;

  // Responses still owed by the block, oldest first
  ils_out_t              owed_rsp [$];
  ils_out_t              want;

  initial begin
    mismatches  = 0;
    checked     = 0;
    full_hits   = 0;
    empty_hits  = 0;
    outstanding = 0;
    list_count  = '0;
    word_count  = 0;
  end

  task automatic report_mismatch(string what);
    if (mismatches < 40)
      $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatches++;
  endtask

  // Open a gap at p, move later words up, store d there
  function automatic void shift_in(int unsigned p, logic [WORD_W-1:0] d);
    for (int unsigned i = word_count; i > p; i--)
      stored_words[i] = stored_words[i-1];
    stored_words[p] = d[DATA_WIDTH-1:0];
    word_count++;
  endfunction

  // Apply one request to the local list and build its response
  function automatic ils_out_t apply_list_op(ils_in_t t);
    ils_out_t    r;
    int unsigned p;
    int unsigned at;
    r = '0;
    p = t.position;
    case (op_e'(t.op))
      OP_INSERT: begin
        if (p > word_count)
          r.status = ST_RANGE;
        else if (word_count >= CAPACITY)
          r.status = ST_FULL;
        else
          shift_in(p, t.data_in);
      end
      OP_REMOVE: begin
        if (word_count == 0)
          r.status = ST_EMPTY;
        else if (p > word_count)
          r.status = ST_RANGE;
        else begin
          // a position equal to the count takes the last word
          at = (p == word_count) ? word_count - 1 : p;
          r.data_out = WORD_W'(stored_words[at]);
          for (int unsigned i = at; i + 1 < word_count; i++)
            stored_words[i] = stored_words[i+1];
          word_count--;
        end
      end
      OP_GET: begin
        if (word_count == 0)
          r.status = ST_EMPTY;
        else if (p >= word_count)
          r.status = ST_RANGE;
        else
          r.data_out = WORD_W'(stored_words[p]);
      end
      OP_SET: begin
        if (p > word_count)
          r.status = ST_RANGE;
        else if (p == word_count) begin
          // set at the count appends, returning zero
          if (word_count >= CAPACITY)
            r.status = ST_FULL;
          else
            shift_in(p, t.data_in);
        end else begin
          stored_words[p] = t.data_in[DATA_WIDTH-1:0];
          r.data_out      = WORD_W'(stored_words[p]);
        end
      end
    endcase
    r.count_after = CNT_W'(word_count);
    return r;
  endfunction

  // Retire responses first: a response never belongs to a request
  // taken in the same cycle
  always @(posedge clk) begin
    if (rst) begin
      owed_rsp.delete();
      word_count = 0;
      outstanding <= 0;
      list_count  <= '0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (owed_rsp.size() == 0)
          report_mismatch("response transaction with no request outstanding");
        else begin
          want = owed_rsp.pop_front();
          checked++;
          if (rsp.data_out !== want.data_out)
            report_mismatch($sformatf("data_out got %08h want %08h",
                                      rsp.data_out, want.data_out));
          if (rsp.count_after !== want.count_after)
            report_mismatch($sformatf("count_after got %0d want %0d",
                                      rsp.count_after, want.count_after));
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      rsp.status, want.status));
          if (want.status == ST_FULL)  full_hits++;
          if (want.status == ST_EMPTY) empty_hits++;
        end
      end
      if (req_valid && req_ready)
        owed_rsp.push_back(apply_list_op(req));
      outstanding <= owed_rsp.size();
      list_count  <= CNT_W'(word_count);
    end
  end

endmodule

// File: dv/tb_indexed_list_store.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_list_store: testbench for the indexed list store
// Drives a directed run over the empty, full and out-of-range cases, then
// random traffic in fill, drain and mixed phases with random stalls on
// both channels. A separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_indexed_list_store;
  import ils_pkg::*;

  typedef enum int {
    PH_FILL,
    PH_DRAIN,
    PH_MIX
  } phase_e;

  logic              clk;
  logic              rst       = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  ils_in_t           req       = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  ils_out_t          rsp;

  // Stalls are switched off while steady is high
  logic              steady    = 1'b0;

  int                mismatches;
  int                outstanding;
  int                checked;
  int                full_hits;
  int                empty_hits;
  logic [CNT_W-1:0]  list_count;
  int                sent      = 0;

  indexed_list_store i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  ils_list_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked),
    .full_hits   (full_hits),
    .empty_hits  (empty_hits),
    .list_count  (list_count)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver stalls at random, with a 6 percent chance, unless steady is high
  always @(posedge clk) begin
    rsp_ready <= steady || ($urandom_range(0, 99) >= 6);
  end

  // Offer one request transaction, with random idle cycles ahead of it
  task automatic send_item(op_e o, int unsigned p, logic [WORD_W-1:0] d);
    while (!steady && $urandom_range(0, 99) < 6) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= '{op: o, position: POS_W'(p), data_in: d};
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sent++;
  endtask

  // Stimulus
  initial begin
    phase_e            ph;
    int                phase_end;
    int unsigned       hint;
    int unsigned       pos;
    int unsigned       pick;
    int                directed;
    op_e               o;
    logic [WORD_W-1:0] d;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Empty list: remove and get refused, writes beyond the end refused
    send_item(OP_REMOVE, 0, 32'h1234_5678);
    send_item(OP_REMOVE, 16, 32'h0);
    send_item(OP_GET, 0, 32'h0);
    send_item(OP_INSERT, 1, 32'hDEAD_BEEF);
    send_item(OP_SET, 2, 32'hCAFE_F00D);
    // Append by set, insert at front and at the count
    send_item(OP_SET, 0, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 0, 32'h0);
    send_item(OP_INSERT, 2, 32'h8000_0001);
    send_item(OP_GET, 2, 32'h0);
    // Fill to capacity
    for (int k = 0; k < 13; k++)
      send_item(OP_INSERT, $urandom_range(0, 3 + k), $urandom);
    // Full list
    send_item(OP_INSERT, 16, 32'h1111_1111);
    send_item(OP_SET, 16, 32'h2222_2222);
    send_item(OP_INSERT, 3, 32'h3333_3333);
    send_item(OP_SET, 5, 32'hA5A5_A5A5);
    send_item(OP_GET, 15, 32'h0);
    send_item(OP_GET, 16, 32'h0);
    // Remove at the count takes the last entry; then past the end
    send_item(OP_REMOVE, 16, 32'h0);
    send_item(OP_REMOVE, 16, 32'h0);
    send_item(OP_INSERT, 16, 32'h4444_4444);
    send_item(OP_REMOVE, 0, 32'h0);
    directed = sent;

    // Random phases: mostly positions near the live range of the list
    ph        = PH_FILL;
    phase_end = 0;
    for (int n = 0; n < 1250; n++) begin
      if (n == phase_end) begin
        ph        = phase_e'($urandom_range(0, 2));
        phase_end = n + $urandom_range(20, 70);
      end
      steady <= (n >= 500 && n < 800);
      hint = list_count;
      pick = $urandom_range(0, 99);
      case (ph)
        PH_FILL:
          o = (pick < 55) ? OP_INSERT : (pick < 75) ? OP_SET :
              (pick < 90) ? OP_GET : OP_REMOVE;
        PH_DRAIN:
          o = (pick < 55) ? OP_REMOVE : (pick < 75) ? OP_GET :
              (pick < 88) ? OP_SET : OP_INSERT;
        default:
          o = op_e'($urandom_range(0, 3));
      endcase
      if ($urandom_range(0, 99) < 85)
        pos = $urandom_range(0, (hint < 16) ? hint + 1 : 16);
      else
        pos = $urandom_range(0, 16);
      case ($urandom_range(0, 9))
        0:       d = '0;
        1:       d = '1;
        default: d = $urandom;
      endcase
      send_item(o, pos, d);
    end
    req_valid <= 1'b0;

    // Drain: let the last request register, then wait for every response
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Ran %0d requests (%0d directed); %0d responses checked.",
             sent, directed, checked);
    $display("Full status seen %0d times, empty status %0d times.",
             full_hits, empty_hits);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timeout with %0d responses outstanding", outstanding);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
